// ===== rtl/token_number_parser_top_assert.svh =====
// Assertion macros for the token number parser.
`ifndef TOKEN_NUMBER_PARSER_TOP_ASSERT_SVH
`define TOKEN_NUMBER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TNP_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("token parser check failed");

// Next-cycle implication, disabled during reset.
`define TNP_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("token parser check failed");

`endif

// ===== rtl/tnp_pkg.sv =====
package tnp_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CHAR_H     = 8'h68;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] OFF_LOWER  = CHAR_LOW_A - 8'd10;
  localparam logic [7:0] OFF_UPPER  = CHAR_UP_A - 8'd10;

  localparam logic [7:0] BASE_BIN = 8'd2;
  localparam logic [7:0] BASE_DEC = 8'd10;
  localparam logic [7:0] BASE_HEX = 8'd16;

  localparam logic [1:0] POS_MAX = 2'd2;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    logic        in_token;
    logic [1:0]  position;
    radix_t      radix;
    logic [31:0] accum;
    logic        failed;
    logic        bare_prefix;
  } token_state_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    logic        ok;
  } token_result_t;

  localparam token_state_t TOKEN_IDLE = '{
    in_token:    1'b0,
    position:    2'd0,
    radix:       RADIX_DEC,
    accum:       32'd0,
    failed:      1'b0,
    bare_prefix: 1'b0
  };

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] off;
    if (c >= CHAR_LOW_A) begin
      off = OFF_LOWER;
    end else if (c >= CHAR_UP_A) begin
      off = OFF_UPPER;
    end else if (c <= CHAR_NINE) begin
      off = CHAR_ZERO;
    end else begin
      off = 8'd0;
    end
    return c - off;
  endfunction

endpackage

// ===== rtl/tnp_in_stage.sv =====
module tnp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_in_line,
  input  logic       take,
  output logic       q_valid,
  output logic [7:0] q_char,
  output logic       q_last
);

  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_char <= char_in;
      q_last <= last_in_line;
    end
  end

endmodule

// ===== rtl/tnp_core.sv =====
module tnp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             q_char,
  input  logic                   q_last,
  output tnp_pkg::token_result_t res,
  output tnp_pkg::token_state_t  st
);

  tnp_pkg::token_state_t st_next;
  tnp_pkg::token_state_t taken;
  tnp_pkg::token_state_t src;
  logic                  is_ws;
  logic                  prefix;
  logic [7:0]            digit;
  logic [7:0]            base;
  logic [31:0]           scaled;

  assign is_ws = (q_char == tnp_pkg::CHAR_SPACE) || (q_char == tnp_pkg::CHAR_TAB);
  assign digit = tnp_pkg::digit_value(q_char);

  always_comb begin
    case (st.radix)
      tnp_pkg::RADIX_BIN: begin
        base   = tnp_pkg::BASE_BIN;
        scaled = {st.accum[30:0], 1'b0};
      end
      tnp_pkg::RADIX_HEX: begin
        base   = tnp_pkg::BASE_HEX;
        scaled = {st.accum[27:0], 4'b0};
      end
      default: begin
        base   = tnp_pkg::BASE_DEC;
        scaled = {st.accum[28:0], 3'b0} + {st.accum[30:0], 1'b0};
      end
    endcase
  end

  always_comb begin
    taken          = st;
    prefix         = 1'b0;
    taken.in_token = 1'b1;
    if (st.position < tnp_pkg::POS_MAX) begin
      taken.position = st.position + 2'd1;
    end
    if (!st.failed) begin
      taken.bare_prefix = 1'b0;
      if (st.accum == 32'd0) begin
        if (st.position <= 2'd1 && q_char == tnp_pkg::CHAR_B) begin
          taken.radix       = tnp_pkg::RADIX_BIN;
          prefix            = 1'b1;
          taken.bare_prefix = (st.position == 2'd0);
        end else if (st.position == 2'd0 && q_char == tnp_pkg::CHAR_H) begin
          taken.radix       = tnp_pkg::RADIX_HEX;
          prefix            = 1'b1;
          taken.bare_prefix = 1'b1;
        end else if (st.position == 2'd1 && q_char == tnp_pkg::CHAR_X) begin
          taken.radix       = tnp_pkg::RADIX_HEX;
          prefix            = 1'b1;
          taken.bare_prefix = 1'b1;
        end
      end
      if (!prefix) begin
        if (digit < base) begin
          taken.accum = scaled + {24'd0, digit};
        end else begin
          taken.failed = 1'b1;
        end
      end
    end
  end

  always_comb begin
    src       = is_ws ? st : taken;
    res.emit  = is_ws ? st.in_token : q_last;
    res.ok    = !src.failed && !src.bare_prefix;
    res.value = res.ok ? src.accum : 32'd0;
    st_next   = (is_ws || q_last) ? tnp_pkg::TOKEN_IDLE : taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tnp_pkg::TOKEN_IDLE;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

// ===== rtl/tnp_out_stage.sv =====
module tnp_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  tnp_pkg::token_result_t res,
  output logic                   out_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            value,
  output logic                   ok
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      value <= res.value;
      ok    <= res.ok;
    end
  end

endmodule

// ===== rtl/token_number_parser_top.sv =====
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | char_in[7:0], last_in_line
// output   | out_valid / out_ready| value[31:0], ok
//
// One byte per cycle sustained unless a stalled output holds an emitting byte;
// a taken byte passes the input register, then its result the result register.
// The token state updates in the single stage between those registers.
// Reset clears both valid flags and the token state.
// A stalled output holds the byte in the input register only if it emits.
`include "token_number_parser_top_assert.svh"

module token_number_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        last_in_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic        ok
);

  logic                   q_valid;
  logic [7:0]             q_char;
  logic                   q_last;
  logic                   fire;
  logic                   out_free;
  logic                   q_ws;
  tnp_pkg::token_result_t res;
  tnp_pkg::token_state_t  st;

  assign fire = q_valid && (!res.emit || out_free);
  assign q_ws = (q_char == tnp_pkg::CHAR_SPACE) || (q_char == tnp_pkg::CHAR_TAB);

  tnp_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .last_in_line (last_in_line),
    .take         (fire),
    .q_valid      (q_valid),
    .q_char       (q_char),
    .q_last       (q_last)
  );

  tnp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .q_char (q_char),
    .q_last (q_last),
    .res    (res),
    .st     (st)
  );

  tnp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res.emit),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .ok        (ok)
  );

  `TNP_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !ok, value == 32'd0)
  `TNP_ASSERT_NOW(a_idle_clear, clk, rst, !st.in_token, st.position == 2'd0 && st.accum == 32'd0)
  `TNP_ASSERT_NEXT(a_ws_ends, clk, rst, fire && q_ws, !st.in_token)
  `TNP_ASSERT_NEXT(a_emit_load, clk, rst, fire && res.emit, out_valid)

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PCT     = 37;

  typedef struct packed {
    logic [31:0] value;
    logic        ok;
  } parsed_number_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = 8'd0;
  logic        last_in_line = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;
  logic        ok;

  token_number_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .last_in_line (last_in_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .ok           (ok)
  );

  parsed_number_t expected_numbers[$];
  logic [7:0]     line_buf[$];

  logic             tok_open;
  logic [1:0]       tok_pos;
  tnp_pkg::radix_t  tok_radix;
  logic [31:0]      tok_acc;
  logic             tok_bad;
  logic             tok_bare;

  logic calm = 1'b0;
  int   errors = 0;
  int   cycles = 0;
  int   bytes_sent = 0;
  int   lines_sent = 0;
  int   numbers_checked = 0;
  int   numbers_rejected = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d numbers outstanding",
               cycles, expected_numbers.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    errors++;
  endtask

  // expected number tracking
  function automatic logic [7:0] char_weight(input logic [7:0] c);
    logic [7:0] w;
    if (c >= tnp_pkg::CHAR_LOW_A) begin
      w = c - tnp_pkg::CHAR_LOW_A + 8'd10;
    end else if (c >= tnp_pkg::CHAR_UP_A) begin
      w = c - tnp_pkg::CHAR_UP_A + 8'd10;
    end else if (c <= tnp_pkg::CHAR_NINE) begin
      w = c - tnp_pkg::CHAR_ZERO;
    end else begin
      w = c;
    end
    return w;
  endfunction

  function automatic logic [31:0] base_for(input tnp_pkg::radix_t r);
    case (r)
      tnp_pkg::RADIX_BIN: return {24'd0, tnp_pkg::BASE_BIN};
      tnp_pkg::RADIX_HEX: return {24'd0, tnp_pkg::BASE_HEX};
      default:            return {24'd0, tnp_pkg::BASE_DEC};
    endcase
  endfunction

  task automatic clear_token();
    tok_open  = 1'b0;
    tok_pos   = 2'd0;
    tok_radix = tnp_pkg::RADIX_DEC;
    tok_acc   = 32'd0;
    tok_bad   = 1'b0;
    tok_bare  = 1'b0;
  endtask

  task automatic close_token();
    parsed_number_t n;
    if (tok_open) begin
      n.ok    = !tok_bad && !tok_bare;
      n.value = n.ok ? tok_acc : 32'd0;
      if (!n.ok) numbers_rejected++;
      expected_numbers.push_back(n);
    end
    clear_token();
  endtask

  task automatic absorb_char(input logic [7:0] c);
    logic [1:0]  at;
    logic        took_prefix;
    logic [7:0]  w;
    logic [31:0] b;
    at          = tok_pos;
    took_prefix = 1'b0;
    tok_open    = 1'b1;
    if (tok_pos != tnp_pkg::POS_MAX) tok_pos = tok_pos + 2'd1;
    if (!tok_bad) begin
      tok_bare = 1'b0;
      if (tok_acc == 32'd0) begin
        if (at <= 2'd1 && c == tnp_pkg::CHAR_B) begin
          tok_radix   = tnp_pkg::RADIX_BIN;
          took_prefix = 1'b1;
          tok_bare    = (at == 2'd0);
        end else if (at == 2'd0 && c == tnp_pkg::CHAR_H) begin
          tok_radix   = tnp_pkg::RADIX_HEX;
          took_prefix = 1'b1;
          tok_bare    = 1'b1;
        end else if (at == 2'd1 && c == tnp_pkg::CHAR_X) begin
          tok_radix   = tnp_pkg::RADIX_HEX;
          took_prefix = 1'b1;
          tok_bare    = 1'b1;
        end
      end
      if (!took_prefix) begin
        w = char_weight(c);
        b = base_for(tok_radix);
        if ({24'd0, w} < b) begin
          tok_acc = tok_acc * b + {24'd0, w};
        end else begin
          tok_bad = 1'b1;
        end
      end
    end
  endtask

  task automatic track_char(input logic [7:0] c, input logic last);
    if (c == tnp_pkg::CHAR_SPACE || c == tnp_pkg::CHAR_TAB) begin
      close_token();
    end else begin
      absorb_char(c);
      if (last) close_token();
    end
  endtask

  // result checking
  always @(posedge clk) begin : check_results
    parsed_number_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_numbers.size() == 0) begin
          report_mismatch("unexpected result value", value, 32'd0);
        end else begin
          want = expected_numbers.pop_front();
          if (value !== want.value) report_mismatch("value", value, want.value);
          if (ok !== want.ok) report_mismatch("ok", {31'd0, ok}, {31'd0, want.ok});
          numbers_checked++;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // byte transfer
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_in      <= c;
    last_in_line <= last;
    do @(posedge clk); while (!in_ready);
    track_char(c, last);
    bytes_sent++;
  endtask

  task automatic send_line();
    int k;
    for (k = 0; k < line_buf.size(); k++) begin
      send_byte(line_buf[k], k == line_buf.size() - 1);
    end
    if (line_buf.size() != 0) lines_sent++;
    line_buf.delete();
  endtask

  task automatic put_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
  endtask

  task automatic put_gap();
    int k;
    int n;
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      line_buf.push_back($urandom_range(1) ? tnp_pkg::CHAR_SPACE : tnp_pkg::CHAR_TAB);
    end
  endtask

  function automatic logic [7:0] hex_char(input int idx);
    if (idx < 10) return tnp_pkg::CHAR_ZERO + 8'(idx);
    if (idx < 16) return tnp_pkg::CHAR_LOW_A + 8'(idx - 10);
    return tnp_pkg::CHAR_UP_A + 8'(idx - 16);
  endfunction

  function automatic logic [7:0] alnum_char();
    case ($urandom_range(2))
      0:       return tnp_pkg::CHAR_ZERO + 8'($urandom_range(9));
      1:       return tnp_pkg::CHAR_LOW_A + 8'($urandom_range(25));
      default: return tnp_pkg::CHAR_UP_A + 8'($urandom_range(25));
    endcase
  endfunction

  task automatic put_digits(input tnp_pkg::radix_t r, input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case (r)
        tnp_pkg::RADIX_BIN: line_buf.push_back(tnp_pkg::CHAR_ZERO + 8'($urandom_range(1)));
        tnp_pkg::RADIX_HEX: line_buf.push_back(hex_char($urandom_range(21)));
        default:            line_buf.push_back(tnp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      endcase
    end
  endtask

  task automatic put_token();
    int start;
    int k;
    int n;
    start = line_buf.size();
    case ($urandom_range(9))
      0, 1, 2: begin
        n = ($urandom_range(4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
        put_digits(tnp_pkg::RADIX_DEC, n);
      end
      3: begin
        line_buf.push_back(tnp_pkg::CHAR_B);
        put_digits(tnp_pkg::RADIX_BIN, $urandom_range(0, 34));
      end
      4: begin
        put_text("0b");
        put_digits(tnp_pkg::RADIX_BIN, $urandom_range(1, 12));
      end
      5: begin
        line_buf.push_back(tnp_pkg::CHAR_H);
        put_digits(tnp_pkg::RADIX_HEX, $urandom_range(0, 9));
      end
      6: begin
        put_text("0x");
        put_digits(tnp_pkg::RADIX_HEX, $urandom_range(0, 9));
      end
      7, 8: begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) line_buf.push_back(alnum_char());
      end
      default: begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) line_buf.push_back(8'($urandom_range(255)));
      end
    endcase
    // corrupt one byte of the odd token
    if (line_buf.size() > start && $urandom_range(11) == 0) begin
      line_buf[$urandom_range(start, line_buf.size() - 1)] = 8'($urandom_range(255));
    end
  endtask

  task automatic build_random_line();
    int k;
    int n;
    if ($urandom_range(19) == 0) begin
      put_gap();
    end else begin
      if ($urandom_range(3) == 0) put_gap();
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        put_token();
        if (k != n - 1) put_gap();
      end
      if ($urandom_range(3) == 0) put_gap();
    end
  endtask

  // tests
  task automatic test_prefixes();
    put_text("h");      send_line();
    put_text("0x");     send_line();
    put_text("b101 ");  send_line();
    put_text("0xFf\t"); send_line();
  endtask

  task automatic test_bad_digits();
    put_text("9z");     send_line();
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  task automatic test_blank_lines();
    put_text("0");      send_line();
    put_text("\t");     send_line();
    put_text(" 7 ");    send_line();
  endtask

  task automatic test_wrap_values();
    put_text("hFFFFFFFF 4294967296"); send_line();
  endtask

  task automatic test_random_lines(input int budget);
    int stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      build_random_line();
      send_line();
    end
  endtask

  task automatic test_steady_stream(input int budget);
    calm = 1'b1;
    test_random_lines(budget);
    calm = 1'b0;
  endtask

  task automatic test_noise_lines(input int budget);
    int stop_at;
    int k;
    int n;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      n = $urandom_range(1, 12);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(1)) line_buf.push_back(8'($urandom_range(255)));
        else line_buf.push_back(alnum_char());
      end
      send_line();
    end
  endtask

  initial begin
    clear_token();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_prefixes();
    test_bad_digits();
    test_blank_lines();
    test_wrap_values();
    test_random_lines(1100);
    test_steady_stream(300);
    test_noise_lines(300);

    in_valid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d lines, with and without back-pressure", bytes_sent,
             lines_sent);
    $display("checked %0d numbers, %0d of them rejected tokens", numbers_checked,
             numbers_rejected);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
